// ----- rtl/core/similarity_warp_pixel_jacobian_assert.svh -----
// Assertion macros shared by the similarity warp Jacobian RTL.
`ifndef SIMILARITY_WARP_PIXEL_JACOBIAN_ASSERT_SVH
`define SIMILARITY_WARP_PIXEL_JACOBIAN_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define SWPJ_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("similarity_warp_pixel_jacobian: check failed");

// Check a condition in the cycle after its trigger.
`define SWPJ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("similarity_warp_pixel_jacobian: check failed");

`endif

// ----- rtl/core/swpj_pkg.sv -----
// Package: types, codes and rounding helper for the similarity warp Jacobian.
package swpj_pkg;

    // Pipeline depth from request to result.
    localparam int PIPE_DEPTH = 10;

    // Width of the value handed to the rounding helper.
    localparam int RS_W = 82;
    localparam logic signed [RS_W-1:0] RND_HALF = RS_W'(32768);
    localparam logic signed [47:0] POS48 = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] NEG48 = {1'b1, {47{1'b0}}};

    // 1.0 in Q16.16 on the 33-bit diagonal.
    localparam logic signed [32:0] ONE_Q16 = 33'sd65536;
    localparam logic [31:0] RDET_RESET = 32'd65536;

    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_WARPED = 2'd1,
        MODE_APPROX = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_SCALE = 2'd1,
        REG_ROT   = 2'd2,
        REG_RDET  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } xy32_t;

    typedef struct packed {
        logic signed [47:0] x;
        logic signed [47:0] y;
    } xy48_t;

    // Drop 16 fraction bits, round half up, saturate to 48 bits signed.
    function automatic logic signed [47:0] round_sat(input logic signed [RS_W-1:0] v);
        logic signed [RS_W-1:0]  t;
        logic signed [RS_W-17:0] q;
        logic [RS_W-17-47:0]     top;
        t   = v + RND_HALF;
        q   = t[RS_W-1:16];
        top = q[RS_W-17:47];
        if ((&top) || (~|top)) begin
            return $signed(q[47:0]);
        end
        else if (top[RS_W-17-47]) begin
            return NEG48;
        end
        else begin
            return POS48;
        end
    endfunction

endpackage

// ----- rtl/core/similarity_warp_pixel_jacobian.sv -----
// Top level: pipelined Jacobian of intensity for a 4-parameter similarity warp.
//
// One request (a template point and one channel's gradient) is taken on every
// clock edge where start is high; busy is never raised, so the block takes a
// new request in every cycle. Each request yields one result, shown for a
// single cycle with result_valid high; the receiver cannot stall it, so no
// result is ever held back or buffered. The result passes through ten register
// stages: two 33x32 and two 32x32 products, their sum, a rounding step,
// the multiply by the reciprocal determinant in two halves, mode selection,
// the eight partial products of the outer terms, their assembly, the final
// sums and the last round and saturate. Configuration writes (cfg_ready is
// always high) should be made only while no request is in flight; they take
// effect on the next edge. In init mode the gradient passes as it is, in
// warped mode it is multiplied by [[1+a, b], [-b, 1+a]], and in approx mode by
// [[1+a, -b], [b, 1+a]] and then by the reciprocal determinant. All values
// are Q16.16; every product is rounded half up and saturated to 48 bits.
`include "similarity_warp_pixel_jacobian_assert.svh"

module similarity_warp_pixel_jacobian (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [31:0]       point_x,
    input  logic signed [31:0]       point_y,
    input  logic signed [31:0]       grad_x,
    input  logic signed [31:0]       grad_y,
    input  logic                     last_in,
    output logic                     result_valid,
    output logic signed [47:0]       jac_tx,
    output logic signed [47:0]       jac_ty,
    output logic signed [47:0]       jac_a,
    output logic signed [47:0]       jac_b,
    output logic                     last_out,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  swpj_pkg::cfg_index_t     cfg_index,
    input  logic [31:0]              cfg_data
);

    import swpj_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]         mode_reg, mode_next;
    logic signed [32:0] diag_reg, diag_next;     // 1 + a, 33 bits
    logic signed [31:0] rot_reg, rot_next;       // b
    logic [31:0]        rdet_reg, rdet_next;     // reciprocal determinant
    logic               cfg_write;
    logic               scale_write;
    logic signed [32:0] scale_diag;              // 1 + a from the write data

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign scale_write = cfg_write && (cfg_index == REG_SCALE);
    assign scale_diag  = 33'($signed(cfg_data)) + ONE_Q16;

    always_comb
    begin
        mode_next = mode_reg;
        diag_next = diag_reg;
        rot_next  = rot_reg;
        rdet_next = rdet_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                REG_MODE:  mode_next = cfg_data[1:0];
                REG_SCALE: diag_next = scale_diag;
                REG_ROT:   rot_next  = $signed(cfg_data);
                REG_RDET:  rdet_next = cfg_data;
                default:   mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_INIT;
            diag_reg <= ONE_Q16;
            rot_reg  <= '0;
            rdet_reg <= RDET_RESET;
        end
        else begin
            mode_reg <= mode_next;
            diag_reg <= diag_next;
            rot_reg  <= rot_next;
            rdet_reg <= rdet_next;
        end
    end

    // ------------------------------------------------------------------
    // Valid and frame-tag shift lines
    // ------------------------------------------------------------------
    logic                  accept;
    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic [PIPE_DEPTH-1:0] last_reg, last_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], accept};
    assign last_next  = {last_reg[PIPE_DEPTH-2:0], last_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
    end

    // ------------------------------------------------------------------
    // Side lines: point to stage 6, gradient to stage 5,
    // (u, v) from stage 3 to 5, (Ix, Iy) from stage 6 to 9
    // ------------------------------------------------------------------
    xy32_t pt_reg   [0:5];
    xy32_t pt_next  [0:5];
    xy32_t grd_reg  [0:4];
    xy32_t grd_next [0:4];
    xy48_t uv_reg   [0:2];
    xy48_t uv_next  [0:2];
    xy48_t ixy_reg  [0:3];
    xy48_t ixy_next [0:3];

    // ------------------------------------------------------------------
    // Arithmetic stage registers
    // ------------------------------------------------------------------
    // Stage 1: matrix products
    logic signed [64:0] p_gx_reg, p_gx_next, b_gy_reg, b_gy_next;
    logic signed [64:0] b_gx_reg, b_gx_next, p_gy_reg, p_gy_next;
    // Stage 2: matrix sums
    logic signed [65:0] u_sum_reg, u_sum_next, v_sum_reg, v_sum_next;
    // Stage 4: partial products with the reciprocal determinant
    logic signed [64:0] u_hi_pp_reg, u_hi_pp_next, v_hi_pp_reg, v_hi_pp_next;
    logic [47:0]        u_lo_pp_reg, u_lo_pp_next, v_lo_pp_reg, v_lo_pp_next;
    // Stage 5: full products with the reciprocal determinant
    logic signed [80:0] u_r_reg, u_r_next, v_r_reg, v_r_next;
    // Stage 7: partial products of the outer terms
    logic signed [63:0] ixh_x_reg, ixh_x_next, iyh_y_reg, iyh_y_next;
    logic signed [63:0] iyh_x_reg, iyh_x_next, ixh_y_reg, ixh_y_next;
    logic signed [48:0] ixl_x_reg, ixl_x_next, iyl_y_reg, iyl_y_next;
    logic signed [48:0] iyl_x_reg, iyl_x_next, ixl_y_reg, ixl_y_next;
    // Stage 8: full outer products
    logic signed [79:0] ixx_reg, ixx_next, iyy_reg, iyy_next;
    logic signed [79:0] iyx_reg, iyx_next, ixy_prod_reg, ixy_prod_next;
    // Stage 9: outer sums
    logic signed [80:0] ja_sum_reg, ja_sum_next, jb_sum_reg, jb_sum_next;
    // Stage 10: results
    logic signed [47:0] jac_tx_reg, jac_tx_next, jac_ty_reg, jac_ty_next;
    logic signed [47:0] jac_a_reg, jac_a_next, jac_b_reg, jac_b_next;

    always_comb
    begin
        // Side lines: advance one stage per cycle.
        pt_next[0]  = '{x: point_x, y: point_y};
        grd_next[0] = '{x: grad_x, y: grad_y};
        for (int i = 1; i < 6; i++) begin
            pt_next[i] = pt_reg[i-1];
        end
        for (int i = 1; i < 5; i++) begin
            grd_next[i] = grd_reg[i-1];
        end

        // Stage 1: (1+a) and b against both gradient components.
        p_gx_next = 65'(diag_reg) * 65'(grad_x);
        b_gy_next = 65'(rot_reg) * 65'(grad_y);
        b_gx_next = 65'(rot_reg) * 65'(grad_x);
        p_gy_next = 65'(diag_reg) * 65'(grad_y);

        // Stage 2: the sign of b follows the mode.
        if (mode_reg == MODE_APPROX) begin
            u_sum_next = 66'(p_gx_reg) - 66'(b_gy_reg);
            v_sum_next = 66'(b_gx_reg) + 66'(p_gy_reg);
        end
        else begin
            u_sum_next = 66'(p_gx_reg) + 66'(b_gy_reg);
            v_sum_next = 66'(p_gy_reg) - 66'(b_gx_reg);
        end

        // Stage 3: round and saturate the matrix product.
        uv_next[0].x = round_sat(RS_W'(u_sum_reg));
        uv_next[0].y = round_sat(RS_W'(v_sum_reg));
        uv_next[1]   = uv_reg[0];
        uv_next[2]   = uv_reg[1];

        // Stage 4: split u and v at bit 16 and multiply each half by r.
        u_hi_pp_next = 65'($signed(uv_reg[0].x[47:16])) * 65'($signed({1'b0, rdet_reg}));
        v_hi_pp_next = 65'($signed(uv_reg[0].y[47:16])) * 65'($signed({1'b0, rdet_reg}));
        u_lo_pp_next = 48'(uv_reg[0].x[15:0]) * 48'(rdet_reg);
        v_lo_pp_next = 48'(uv_reg[0].y[15:0]) * 48'(rdet_reg);

        // Stage 5: recombine the halves.
        u_r_next = (81'(u_hi_pp_reg) <<< 16) + $signed({33'b0, u_lo_pp_reg});
        v_r_next = (81'(v_hi_pp_reg) <<< 16) + $signed({33'b0, v_lo_pp_reg});

        // Stage 6: pick the gradient (Ix, Iy) for the mode.
        unique case (mode_reg)
            MODE_WARPED:
            begin
                ixy_next[0] = uv_reg[2];
            end
            MODE_APPROX:
            begin
                ixy_next[0].x = round_sat(RS_W'(u_r_reg));
                ixy_next[0].y = round_sat(RS_W'(v_r_reg));
            end
            default:
            begin
                ixy_next[0].x = 48'(grd_reg[4].x);
                ixy_next[0].y = 48'(grd_reg[4].y);
            end
        endcase
        for (int i = 1; i < 4; i++) begin
            ixy_next[i] = ixy_reg[i-1];
        end

        // Stage 7: split Ix and Iy at bit 16 against x and y.
        ixh_x_next = 64'($signed(ixy_reg[0].x[47:16])) * 64'(pt_reg[5].x);
        ixl_x_next = 49'($signed({1'b0, ixy_reg[0].x[15:0]})) * 49'(pt_reg[5].x);
        iyh_y_next = 64'($signed(ixy_reg[0].y[47:16])) * 64'(pt_reg[5].y);
        iyl_y_next = 49'($signed({1'b0, ixy_reg[0].y[15:0]})) * 49'(pt_reg[5].y);
        iyh_x_next = 64'($signed(ixy_reg[0].y[47:16])) * 64'(pt_reg[5].x);
        iyl_x_next = 49'($signed({1'b0, ixy_reg[0].y[15:0]})) * 49'(pt_reg[5].x);
        ixh_y_next = 64'($signed(ixy_reg[0].x[47:16])) * 64'(pt_reg[5].y);
        ixl_y_next = 49'($signed({1'b0, ixy_reg[0].x[15:0]})) * 49'(pt_reg[5].y);

        // Stage 8: assemble the full products.
        ixx_next      = (80'(ixh_x_reg) <<< 16) + 80'(ixl_x_reg);
        iyy_next      = (80'(iyh_y_reg) <<< 16) + 80'(iyl_y_reg);
        iyx_next      = (80'(iyh_x_reg) <<< 16) + 80'(iyl_x_reg);
        ixy_prod_next = (80'(ixh_y_reg) <<< 16) + 80'(ixl_y_reg);

        // Stage 9: Ix*x + Iy*y and Iy*x - Ix*y.
        ja_sum_next = 81'(ixx_reg) + 81'(iyy_reg);
        jb_sum_next = 81'(iyx_reg) - 81'(ixy_prod_reg);

        // Stage 10: round, saturate and present.
        jac_tx_next = ixy_reg[3].x;
        jac_ty_next = ixy_reg[3].y;
        jac_a_next  = round_sat(RS_W'(ja_sum_reg));
        jac_b_next  = round_sat(RS_W'(jb_sum_reg));
    end

    // Payload needs no reset: valid_reg qualifies every stage.
    always_ff @(posedge clk)
    begin
        pt_reg       <= pt_next;
        grd_reg      <= grd_next;
        uv_reg       <= uv_next;
        ixy_reg      <= ixy_next;
        p_gx_reg     <= p_gx_next;
        b_gy_reg     <= b_gy_next;
        b_gx_reg     <= b_gx_next;
        p_gy_reg     <= p_gy_next;
        u_sum_reg    <= u_sum_next;
        v_sum_reg    <= v_sum_next;
        u_hi_pp_reg  <= u_hi_pp_next;
        v_hi_pp_reg  <= v_hi_pp_next;
        u_lo_pp_reg  <= u_lo_pp_next;
        v_lo_pp_reg  <= v_lo_pp_next;
        u_r_reg      <= u_r_next;
        v_r_reg      <= v_r_next;
        ixh_x_reg    <= ixh_x_next;
        ixl_x_reg    <= ixl_x_next;
        iyh_y_reg    <= iyh_y_next;
        iyl_y_reg    <= iyl_y_next;
        iyh_x_reg    <= iyh_x_next;
        iyl_x_reg    <= iyl_x_next;
        ixh_y_reg    <= ixh_y_next;
        ixl_y_reg    <= ixl_y_next;
        ixx_reg      <= ixx_next;
        iyy_reg      <= iyy_next;
        iyx_reg      <= iyx_next;
        ixy_prod_reg <= ixy_prod_next;
        ja_sum_reg   <= ja_sum_next;
        jb_sum_reg   <= jb_sum_next;
        jac_tx_reg   <= jac_tx_next;
        jac_ty_reg   <= jac_ty_next;
        jac_a_reg    <= jac_a_next;
        jac_b_reg    <= jac_b_next;
    end

    assign result_valid = valid_reg[PIPE_DEPTH-1];
    assign jac_tx       = jac_tx_reg;
    assign jac_ty       = jac_ty_reg;
    assign jac_a        = jac_a_reg;
    assign jac_b        = jac_b_reg;
    assign last_out     = last_reg[PIPE_DEPTH-1];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every result comes from an accepted request.
    `SWPJ_ASSERT_NOW(a_result_latency, result_valid, $past(accept, PIPE_DEPTH))
    // The frame tag leaves with its own request.
    `SWPJ_ASSERT_NOW(a_last_tag, result_valid, last_out == $past(last_in, PIPE_DEPTH))
    // A write of a lands as 1 + a on the diagonal.
    `SWPJ_ASSERT_NEXT(a_diag_write, scale_write, diag_reg == $past(scale_diag))

endmodule
